@@ rtl/sbga_pkg.sv @@
`timescale 1ns / 1ps
// Package for the size-bounded group assigner: category codes, register
// indexes, reset values and fixed thresholds. No dependencies.
package sbga_pkg;

  // Field widths
  localparam int CAT_W   = 3;
  localparam int SIZE_W  = 32;
  localparam int IDX_W   = 20;
  localparam int TOTAL_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Default group counter depth
  localparam int MAX_FILES_DEF = 1048576;

  // Category codes
  localparam logic [CAT_W-1:0] CAT_CONFIG  = 3'd0;
  localparam logic [CAT_W-1:0] CAT_SCRIPTS = 3'd1;
  localparam logic [CAT_W-1:0] CAT_MEDIUM  = 3'd2;
  localparam logic [CAT_W-1:0] CAT_BINARY  = 3'd3;
  localparam logic [CAT_W-1:0] CAT_LARGE   = 3'd4;
  localparam logic [CAT_W-1:0] CAT_SPECIAL = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_TEX_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCRIPTS_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BINARY_LIMIT    = 3'd4;

  // Register reset values
  localparam logic [SIZE_W-1:0] LARGE_TEX_LIMIT_RST = 32'd4194304;
  localparam logic [SIZE_W-1:0] CONFIG_LIMIT_RST    = 32'd262144;
  localparam logic [SIZE_W-1:0] SCRIPTS_LIMIT_RST   = 32'd524288;
  localparam logic [SIZE_W-1:0] MEDIUM_LIMIT_RST    = 32'd1048576;
  localparam logic [SIZE_W-1:0] BINARY_LIMIT_RST    = 32'd1048576;

  // Fixed size thresholds
  localparam logic [SIZE_W-1:0] CONFIG_REFINE_BYTES = 32'd51200;   // 50 KiB
  localparam logic [SIZE_W-1:0] SCRIPT_REFINE_BYTES = 32'd102400;  // 100 KiB
  localparam logic [SIZE_W-1:0] OTHER_GROUP_LIMIT   = 32'd1048576; // undefined codes

endpackage

@@ rtl/size_bounded_group_assigner.sv @@
`timescale 1ns / 1ps
// Size-bounded group assigner: refines a file's category by size and packs
// it next-fit into groups. Depends on sbga_pkg.
//
// Path: input beat to result beat through the input register, then the result register.
// Throughput: one beat per cycle while results are taken; the open-group state is registered on each beat.
// A stalled result holds the pipe; a new beat is still taken while the input register is empty.
// Reset (synchronous, active low): pipe empty, no open group, counters cleared,
// limit registers back to their defaults. No clearing pass.
module size_bounded_group_assigner #(
  parameter int MAX_FILES = sbga_pkg::MAX_FILES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sbga_pkg::CAT_W-1:0]      in_name_category,
  input  logic [sbga_pkg::SIZE_W-1:0]     in_file_size,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sbga_pkg::CAT_W-1:0]      out_final_category,
  output logic [sbga_pkg::IDX_W-1:0]      out_group_index,
  output logic                            out_opened_group,
  output logic                            out_alone_in_group,
  output logic [sbga_pkg::TOTAL_W-1:0]    out_running_total,
  // configuration
  input  logic                            cfg_we,
  input  logic [sbga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbga_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CAT_W   = sbga_pkg::CAT_W;
  localparam int SIZE_W  = sbga_pkg::SIZE_W;
  localparam int IDX_W   = sbga_pkg::IDX_W;
  localparam int TOTAL_W = sbga_pkg::TOTAL_W;
  localparam int CW      = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam logic [CW:0]   GRP_WRAP = (CW+1)'(MAX_FILES);
  localparam logic [CW-1:0] GRP_LAST = CW'(MAX_FILES - 1);

  // Limit registers
  logic [SIZE_W-1:0] large_tex_limit_r, config_limit_r, scripts_limit_r;
  logic [SIZE_W-1:0] medium_limit_r, binary_limit_r;

  // Input stage
  logic              s0_valid_r;
  logic [CAT_W-1:0]  s0_cat_r;
  logic [SIZE_W-1:0] s0_size_r;

  // Packing state
  logic              group_open_r, group_open_nxt;
  logic [CAT_W-1:0]  open_cat_r, open_cat_nxt;
  logic [SIZE_W-1:0] open_bytes_r, open_bytes_nxt;
  logic [CW-1:0]     groups_r, groups_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  // Result register
  logic               out_valid_r;
  logic [CAT_W-1:0]   out_cat_r, out_cat_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_opened_r, out_alone_r;
  logic [TOTAL_W-1:0] out_total_r;

  // Datapath intermediates
  logic              s1_en, step;
  logic [CAT_W-1:0]  fin_cat;
  logic [SIZE_W-1:0] limit;
  logic              alone, need_new, opened;
  logic [SIZE_W:0]   fill_sum;
  logic [CW:0]       grp_inc;
  logic [CW-1:0]     grp_take, idx;
  logic [CW+IDX_W-1:0] idx_wide;

  // Handshake: result register frees when empty or taken
  assign s1_en    = !out_valid_r || out_ready;
  assign in_ready = !s0_valid_r || s1_en;
  assign step     = s0_valid_r && s1_en;

  // Category refinement by size
  always_comb begin
    fin_cat = s0_cat_r;
    if (fin_cat == sbga_pkg::CAT_CONFIG && s0_size_r > sbga_pkg::CONFIG_REFINE_BYTES) begin
      fin_cat = sbga_pkg::CAT_SCRIPTS;
    end
    if (fin_cat == sbga_pkg::CAT_SCRIPTS && s0_size_r > sbga_pkg::SCRIPT_REFINE_BYTES) begin
      fin_cat = sbga_pkg::CAT_MEDIUM;
    end
    if (fin_cat == sbga_pkg::CAT_MEDIUM && s0_size_r > large_tex_limit_r) begin
      fin_cat = sbga_pkg::CAT_LARGE;
    end
  end

  // Group limit per category
  always_comb begin
    case (fin_cat) inside
      sbga_pkg::CAT_CONFIG:  limit = config_limit_r;
      sbga_pkg::CAT_SCRIPTS: limit = scripts_limit_r;
      sbga_pkg::CAT_MEDIUM:  limit = medium_limit_r;
      sbga_pkg::CAT_BINARY:  limit = binary_limit_r;
      sbga_pkg::CAT_LARGE, sbga_pkg::CAT_SPECIAL: limit = '0;
      default:               limit = sbga_pkg::OTHER_GROUP_LIMIT;
    endcase
  end

  // Next-fit decision and group numbering
  always_comb begin
    alone    = (limit == '0) || (s0_size_r > limit);
    fill_sum = {1'b0, open_bytes_r} + {1'b0, s0_size_r};
    need_new = !group_open_r || (open_cat_r != fin_cat) || (fill_sum > {1'b0, limit});
    opened   = alone || need_new;

    grp_inc  = {1'b0, groups_r} + (CW+1)'(1);
    grp_take = (grp_inc >= GRP_WRAP) ? '0 : grp_inc[CW-1:0];

    // a fresh group takes the current count, otherwise the last one handed out
    if (opened) begin
      idx = groups_r;
    end else if (groups_r == '0) begin
      idx = GRP_LAST;
    end else begin
      idx = groups_r - CW'(1);
    end
    idx_wide = {{IDX_W{1'b0}}, idx};

    groups_nxt     = opened ? grp_take : groups_r;
    total_nxt      = total_r + TOTAL_W'(s0_size_r);
    group_open_nxt = group_open_r;
    open_cat_nxt   = open_cat_r;
    open_bytes_nxt = open_bytes_r;
    if (alone) begin
      group_open_nxt = 1'b0;
    end else if (need_new) begin
      group_open_nxt = 1'b1;
      open_cat_nxt   = fin_cat;
      open_bytes_nxt = s0_size_r;
    end else begin
      open_bytes_nxt = fill_sum[SIZE_W-1:0];
    end

    out_cat_nxt = fin_cat;
    out_idx_nxt = idx_wide[IDX_W-1:0];
  end

  // Limit registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_tex_limit_r <= sbga_pkg::LARGE_TEX_LIMIT_RST;
      config_limit_r    <= sbga_pkg::CONFIG_LIMIT_RST;
      scripts_limit_r   <= sbga_pkg::SCRIPTS_LIMIT_RST;
      medium_limit_r    <= sbga_pkg::MEDIUM_LIMIT_RST;
      binary_limit_r    <= sbga_pkg::BINARY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbga_pkg::REG_LARGE_TEX_LIMIT: large_tex_limit_r <= cfg_wdata;
        sbga_pkg::REG_CONFIG_LIMIT:    config_limit_r    <= cfg_wdata;
        sbga_pkg::REG_SCRIPTS_LIMIT:   scripts_limit_r   <= cfg_wdata;
        sbga_pkg::REG_MEDIUM_LIMIT:    medium_limit_r    <= cfg_wdata;
        sbga_pkg::REG_BINARY_LIMIT:    binary_limit_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_cat_r  <= in_name_category;
      s0_size_r <= in_file_size;
    end
  end

  // Packing state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_open_r <= 1'b0;
      open_cat_r   <= sbga_pkg::CAT_SPECIAL;
      open_bytes_r <= '0;
      groups_r     <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_en) begin
        out_valid_r <= s0_valid_r;
      end
      if (step) begin
        group_open_r <= group_open_nxt;
        open_cat_r   <= open_cat_nxt;
        open_bytes_r <= open_bytes_nxt;
        groups_r     <= groups_nxt;
        total_r      <= total_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_cat_r    <= out_cat_nxt;
      out_idx_r    <= out_idx_nxt;
      out_opened_r <= opened;
      out_alone_r  <= alone;
      out_total_r  <= total_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_final_category = out_cat_r;
  assign out_group_index    = out_idx_r;
  assign out_opened_group   = out_opened_r;
  assign out_alone_in_group = out_alone_r;
  assign out_running_total  = out_total_r;

  // A file alone in its group always opens that group
  a_alone_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_alone_r |-> out_opened_r)
    else $error("alone_in_group without opened_group");

  // An own group closes the open group
  a_alone_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_alone_r |-> !group_open_r)
    else $error("group still open after own-group file");

  // A file that joined a group leaves it open under its own category
  a_join_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_opened_r |-> group_open_r && (open_cat_r == out_cat_r))
    else $error("joined file does not match open group");

  // The packing state only moves when a beat moves into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(total_r) && $stable(groups_r))
    else $error("packing state changed without a beat");

endmodule

@@ dv/size_bounded_group_assigner_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for size_bounded_group_assigner: directed and random file
// streams checked against an in-bench next-fit group predictor. Needs sbga_pkg.
module size_bounded_group_assigner_test;

  localparam int CAT_W      = sbga_pkg::CAT_W;
  localparam int SIZE_W     = sbga_pkg::SIZE_W;
  localparam int IDX_W      = sbga_pkg::IDX_W;
  localparam int TOTAL_W    = sbga_pkg::TOTAL_W;
  localparam int CFG_IDX_W  = sbga_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sbga_pkg::CFG_DATA_W;

  // Group counter depth as the block's default
  localparam int GROUP_DEPTH     = sbga_pkg::MAX_FILES_DEF;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_REGS        = 5;
  localparam logic [CAT_W-1:0]  CAT_UNDEF_LO = 3'd6;
  localparam logic [CAT_W-1:0]  CAT_UNDEF_HI = 3'd7;
  localparam logic [SIZE_W-1:0] SIZE_MAX     = '1;

  typedef struct packed {
    logic [CAT_W-1:0]   cat;
    logic [IDX_W-1:0]   grp_index;
    logic               opened;
    logic               alone;
    logic [TOTAL_W-1:0] total;
  } placement_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CAT_W-1:0]      in_name_category = '0;
  logic [SIZE_W-1:0]     in_file_size = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CAT_W-1:0]      out_final_category;
  logic [IDX_W-1:0]      out_group_index;
  logic                  out_opened_group;
  logic                  out_alone_in_group;
  logic [TOTAL_W-1:0]    out_running_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state
  logic [SIZE_W-1:0]  limit_q [NUM_REGS];
  logic               grp_open;
  logic [CAT_W-1:0]   grp_cat;
  logic [SIZE_W-1:0]  grp_bytes;
  int                 groups_taken;
  logic [TOTAL_W-1:0] bytes_seen;
  placement_t         pending_placements [$];

  // Bookkeeping
  int  files_sent, results_seen, random_files, errors;
  int  alone_seen, opened_seen, index_wraps, total_wraps;
  int  stalled_cycles, hold_left;
  bit  gaps_on;
  logic hold_req = 1'b0;

  size_bounded_group_assigner #(.MAX_FILES(GROUP_DEPTH)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_name_category   (in_name_category),
    .in_file_size       (in_file_size),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_final_category (out_final_category),
    .out_group_index    (out_group_index),
    .out_opened_group   (out_opened_group),
    .out_alone_in_group (out_alone_in_group),
    .out_running_total  (out_running_total),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Byte limit of a group for a refined category
  function automatic logic [SIZE_W-1:0] group_limit_of(input logic [CAT_W-1:0] cat);
    case (cat) inside
      sbga_pkg::CAT_CONFIG:  return limit_q[sbga_pkg::REG_CONFIG_LIMIT];
      sbga_pkg::CAT_SCRIPTS: return limit_q[sbga_pkg::REG_SCRIPTS_LIMIT];
      sbga_pkg::CAT_MEDIUM:  return limit_q[sbga_pkg::REG_MEDIUM_LIMIT];
      sbga_pkg::CAT_BINARY:  return limit_q[sbga_pkg::REG_BINARY_LIMIT];
      sbga_pkg::CAT_LARGE, sbga_pkg::CAT_SPECIAL: return '0;
      default:               return sbga_pkg::OTHER_GROUP_LIMIT;
    endcase
  endfunction

  // Hand out the next group number; wraps at the counter depth
  function automatic int take_group();
    int taken;
    taken = groups_taken;
    if (groups_taken + 1 >= GROUP_DEPTH) begin
      groups_taken = 0;
      index_wraps++;
    end else begin
      groups_taken = groups_taken + 1;
    end
    return taken;
  endfunction

  // Refine the category, then place the file next-fit; updates predictor state
  function automatic placement_t place_file(input logic [CAT_W-1:0] name_cat,
                                            input logic [SIZE_W-1:0] sz);
    placement_t         p;
    logic [SIZE_W-1:0]  lim;
    logic [TOTAL_W-1:0] prev_total;
    p.cat = name_cat;
    if (p.cat == sbga_pkg::CAT_CONFIG && sz > sbga_pkg::CONFIG_REFINE_BYTES)
      p.cat = sbga_pkg::CAT_SCRIPTS;
    if (p.cat == sbga_pkg::CAT_SCRIPTS && sz > sbga_pkg::SCRIPT_REFINE_BYTES)
      p.cat = sbga_pkg::CAT_MEDIUM;
    if (p.cat == sbga_pkg::CAT_MEDIUM && sz > limit_q[sbga_pkg::REG_LARGE_TEX_LIMIT])
      p.cat = sbga_pkg::CAT_LARGE;
    lim = group_limit_of(p.cat);

    prev_total = bytes_seen;
    bytes_seen = bytes_seen + TOTAL_W'(sz);
    if (bytes_seen < prev_total) total_wraps++;
    p.total = bytes_seen;

    if (lim == '0 || sz > lim) begin
      // own group; the open group is closed but keeps its category
      p.grp_index = IDX_W'(take_group());
      p.opened = 1'b1;
      p.alone = 1'b1;
      grp_open = 1'b0;
    end else begin
      p.alone = 1'b0;
      p.opened = 1'b0;
      if (!grp_open || grp_cat != p.cat ||
          {1'b0, grp_bytes} + {1'b0, sz} > {1'b0, lim}) begin
        void'(take_group());
        grp_open = 1'b1;
        grp_cat = p.cat;
        grp_bytes = '0;
        p.opened = 1'b1;
      end
      grp_bytes = grp_bytes + sz;
      p.grp_index = IDX_W'((groups_taken == 0) ? GROUP_DEPTH - 1 : groups_taken - 1);
    end
    return p;
  endfunction

  // Sizes biased to the refinement thresholds and the current group limits
  function automatic logic [SIZE_W-1:0] pick_size(input logic [CAT_W-1:0] cat);
    logic [SIZE_W-1:0] lim;
    lim = group_limit_of(cat);
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return sbga_pkg::CONFIG_REFINE_BYTES + $urandom_range(2) - 1;
      2:       return sbga_pkg::SCRIPT_REFINE_BYTES + $urandom_range(2) - 1;
      3:       return limit_q[sbga_pkg::REG_LARGE_TEX_LIMIT] + $urandom_range(2) - 1;
      4:       return lim + $urandom_range(2) - 1;
      default: begin
        if (cat == sbga_pkg::CAT_CONFIG)
          return $urandom_range(sbga_pkg::CONFIG_REFINE_BYTES);
        if (cat == sbga_pkg::CAT_SCRIPTS)
          return $urandom_range(sbga_pkg::SCRIPT_REFINE_BYTES);
        return $urandom_range((lim == '0) ? 32'd65536 : lim >> 2);
      end
    endcase
  endfunction

  function automatic void flag_field(input string field, input logic [TOTAL_W-1:0] want_v,
                                     input logic [TOTAL_W-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: beat %0d %s expected 0x%0h got 0x%0h",
                 $time, results_seen, field, want_v, got_v);
    end
  endfunction

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      pending_placements.insert(pending_placements.size(),
                                place_file(in_name_category, in_file_size));
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    placement_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_alone_in_group === 1'b1) alone_seen++;
      if (out_opened_group === 1'b1) opened_seen++;
      if (pending_placements.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: result beat with nothing predicted", $time);
      end else begin
        want = pending_placements.pop_front();
        flag_field("final_category", TOTAL_W'(want.cat), TOTAL_W'(out_final_category));
        flag_field("group_index", TOTAL_W'(want.grp_index), TOTAL_W'(out_group_index));
        flag_field("opened_group", TOTAL_W'(want.opened), TOTAL_W'(out_opened_group));
        flag_field("alone_in_group", TOTAL_W'(want.alone), TOTAL_W'(out_alone_in_group));
        flag_field("running_total", want.total, out_running_total);
      end
    end
  end

  // Result side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) hold_left = HOLD_CYCLES;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(gaps_on && $urandom_range(99) < 34);
    end
  end

  // Watchdog: cycles in which no beat moves on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stalled_cycles = 0;
    else stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_CYCLES) begin
      $display("Timeout: no beat moved for %0d cycles", stalled_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one file; valid stays up until the beat is taken
  task automatic send_file(input logic [CAT_W-1:0] cat, input logic [SIZE_W-1:0] sz);
    while (gaps_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_name_category <= cat;
    in_file_size <= sz;
    do @(posedge clk); while (!in_ready);
    files_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_seen < files_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < NUM_REGS) limit_q[idx] = val;
  endtask

  // Only called with the block idle
  task automatic program_limits(input logic [SIZE_W-1:0] tex, input logic [SIZE_W-1:0] cfg,
                                input logic [SIZE_W-1:0] scr, input logic [SIZE_W-1:0] med,
                                input logic [SIZE_W-1:0] bin);
    write_reg(sbga_pkg::REG_LARGE_TEX_LIMIT, tex);
    write_reg(sbga_pkg::REG_CONFIG_LIMIT, cfg);
    write_reg(sbga_pkg::REG_SCRIPTS_LIMIT, scr);
    write_reg(sbga_pkg::REG_MEDIUM_LIMIT, med);
    write_reg(sbga_pkg::REG_BINARY_LIMIT, bin);
    // a write past the last register must change nothing
    write_reg(sbga_pkg::REG_BINARY_LIMIT + CFG_IDX_W'($urandom_range(3, 1)), $urandom());
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_defaults();
    program_limits(sbga_pkg::LARGE_TEX_LIMIT_RST, sbga_pkg::CONFIG_LIMIT_RST,
                   sbga_pkg::SCRIPTS_LIMIT_RST, sbga_pkg::MEDIUM_LIMIT_RST,
                   sbga_pkg::BINARY_LIMIT_RST);
  endtask

  // Category thresholds, at and one past each boundary
  task automatic test_refinement();
    send_file(sbga_pkg::CAT_CONFIG, sbga_pkg::CONFIG_REFINE_BYTES);
    send_file(sbga_pkg::CAT_CONFIG, sbga_pkg::CONFIG_REFINE_BYTES + 1);
    send_file(sbga_pkg::CAT_CONFIG, sbga_pkg::SCRIPT_REFINE_BYTES + 1);
    send_file(sbga_pkg::CAT_SCRIPTS, sbga_pkg::SCRIPT_REFINE_BYTES);
    send_file(sbga_pkg::CAT_SCRIPTS, sbga_pkg::SCRIPT_REFINE_BYTES + 1);
    send_file(sbga_pkg::CAT_MEDIUM, sbga_pkg::LARGE_TEX_LIMIT_RST);
    send_file(sbga_pkg::CAT_MEDIUM, sbga_pkg::LARGE_TEX_LIMIT_RST + 1);
    send_file(sbga_pkg::CAT_CONFIG, SIZE_MAX);
    drain_results();
  endtask

  // Next-fit: fill a group, overflow it, exact fit, zero size, own group
  task automatic test_packing();
    repeat (6) send_file(sbga_pkg::CAT_CONFIG, 32'd50000);
    send_file(sbga_pkg::CAT_BINARY, sbga_pkg::BINARY_LIMIT_RST);
    send_file(sbga_pkg::CAT_BINARY, '0);
    send_file(sbga_pkg::CAT_BINARY, 32'd1);
    send_file(sbga_pkg::CAT_BINARY, sbga_pkg::BINARY_LIMIT_RST + 1);
    drain_results();
  endtask

  // Zero-limit categories and the undefined codes with their fixed 1 MiB limit
  task automatic test_odd_codes();
    send_file(sbga_pkg::CAT_LARGE, '0);
    send_file(sbga_pkg::CAT_SPECIAL, 32'd1);
    send_file(CAT_UNDEF_LO, sbga_pkg::OTHER_GROUP_LIMIT);
    send_file(CAT_UNDEF_HI, 32'd10);
    send_file(CAT_UNDEF_HI, sbga_pkg::OTHER_GROUP_LIMIT + 1);
    drain_results();
  endtask

  // All limits at zero, then at maximum (group total overflows 32 bits)
  task automatic test_limit_extremes();
    program_limits('0, '0, '0, '0, '0);
    send_file(sbga_pkg::CAT_CONFIG, '0);
    send_file(sbga_pkg::CAT_MEDIUM, 32'd1);
    drain_results();
    program_limits(SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX);
    send_file(sbga_pkg::CAT_MEDIUM, SIZE_MAX);
    send_file(sbga_pkg::CAT_MEDIUM, SIZE_MAX);
    drain_results();
  endtask

  // Result side held off while the sender keeps offering files
  task automatic test_backpressure();
    logic [CAT_W-1:0] cat;
    program_defaults();
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (24) begin
      cat = CAT_W'($urandom_range(sbga_pkg::CAT_BINARY));
      send_file(cat, pick_size(cat));
    end
    drain_results();
  endtask

  // Runs of one category with random sizes, some category changes
  task automatic run_random_phase(input int count);
    logic [CAT_W-1:0] cat;
    cat = sbga_pkg::CAT_CONFIG;
    repeat (count) begin
      if ($urandom_range(99) >= 70)
        cat = ($urandom_range(99) < 80) ?
              CAT_W'($urandom_range(sbga_pkg::CAT_BINARY)) :
              CAT_W'($urandom_range(CAT_UNDEF_HI, sbga_pkg::CAT_LARGE));
      send_file(cat, pick_size(cat));
      random_files++;
    end
    drain_results();
  endtask

  task automatic test_random();
    gaps_on = 1'b1;
    program_defaults();
    run_random_phase(60);
    program_limits('0, '0, '0, '0, '0);
    run_random_phase(40);
    program_limits(SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX);
    run_random_phase(50);
    program_limits($urandom_range(32'h0020_0000), $urandom_range(300000),
                   $urandom_range(300000), $urandom_range(300000), $urandom_range(300000));
    run_random_phase(60);
    program_limits($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_random_phase(50);
    // long stretch with no idling on either side
    gaps_on = 1'b0;
    program_defaults();
    run_random_phase(90);
  endtask

  initial begin
    limit_q[sbga_pkg::REG_LARGE_TEX_LIMIT] = sbga_pkg::LARGE_TEX_LIMIT_RST;
    limit_q[sbga_pkg::REG_CONFIG_LIMIT]    = sbga_pkg::CONFIG_LIMIT_RST;
    limit_q[sbga_pkg::REG_SCRIPTS_LIMIT]   = sbga_pkg::SCRIPTS_LIMIT_RST;
    limit_q[sbga_pkg::REG_MEDIUM_LIMIT]    = sbga_pkg::MEDIUM_LIMIT_RST;
    limit_q[sbga_pkg::REG_BINARY_LIMIT]    = sbga_pkg::BINARY_LIMIT_RST;
    grp_open = 1'b0;
    grp_cat = sbga_pkg::CAT_SPECIAL;
    grp_bytes = '0;
    groups_taken = 0;
    bytes_seen = '0;
    gaps_on = 1'b1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_refinement();
    test_packing();
    test_odd_codes();
    test_limit_extremes();
    test_backpressure();
    test_random();

    // result latency plus margin before the final tally
    repeat (4) @(posedge clk);
    if (pending_placements.size() != 0) begin
      errors += pending_placements.size();
      $display("%0d predicted results never arrived", pending_placements.size());
    end

    $display("Run covered %0d files (%0d in random phases): %0d own groups, %0d groups opened.",
             files_sent, random_files, alone_seen, opened_seen);
    $display("Group index wrapped %0d times, byte total wrapped %0d times, %0d errors.",
             index_wraps, total_wraps, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
